/* rtl/led_frame_receiver_xor_checksum_unit_assert.svh */
// Assertion macros used by the queue module; empty under synthesis.
`ifndef LED_FRAME_RECEIVER_XOR_CHECKSUM_UNIT_ASSERT_SVH
`define LED_FRAME_RECEIVER_XOR_CHECKSUM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LFXC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LFXC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LFXC_ASSERT(lbl, prop, msg)
`define LFXC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/lfxc_pkg.sv */
// Shared constants, command type and width helpers for the frame receiver.
package lfxc_pkg;

    localparam int LFXC_MAX_PIXELS   = 256;
    localparam int LFXC_QUEUE_DEPTH  = 2;

    localparam logic [7:0]  SYNC_FIRST      = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND     = 8'hAA;
    localparam logic [8:0]  PIX_COUNT_RST   = 9'd73;
    localparam logic [15:0] TIMEOUT_RST     = 16'd50;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_COMMIT    = 3'd1;
    localparam logic [2:0] EV_CSUM_FAIL = 3'd2;
    localparam logic [2:0] EV_TIMEOUT   = 3'd3;
    localparam logic [2:0] EV_READ      = 3'd4;

    localparam logic CFG_PIX_COUNT = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    // one command from the front to the back
    typedef struct packed {
        logic        wr_en;
        logic [1:0]  lane;
        logic [7:0]  wdata;
        logic [2:0]  rd_mask;
        logic [2:0]  ev;
        logic [31:0] good;
        logic [31:0] dropped;
    } t_cmd;

    // bits of a pixel index
    function automatic int lfxc_pix_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // bits of a count up to n
    function automatic int lfxc_cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

/* rtl/lfxc_front.sv */
// Front end: frame sync, checksum, timeout, counters; emits store commands.
module lfxc_front
    import lfxc_pkg::*;
#(
    parameter int MAX_PIXELS = LFXC_MAX_PIXELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic [7:0]                        i_byte,
    input  logic [7:0]                        i_px,
    input  logic                              i_q_full,
    output logic                              o_push,
    output t_cmd                              o_cmd,
    output logic [lfxc_pix_w(MAX_PIXELS):0]   o_addr
);

    localparam int PW   = lfxc_pix_w(MAX_PIXELS);
    localparam int CW   = lfxc_cnt_w(MAX_PIXELS);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam int XW   = (CW > 8) ? CW : 8;

    localparam logic [1:0] ST_SYNC1 = 2'd0;
    localparam logic [1:0] ST_SYNC2 = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [8:0]    r_pix_count;
    logic [15:0]   r_timeout;
    logic [1:0]    r_state,  n_state;
    logic [CW-1:0] r_pix,    n_pix;
    logic [1:0]    r_lane,   n_lane;
    logic [7:0]    r_parity, n_parity;
    logic [15:0]   r_age,    n_age;
    logic          r_bank,   n_bank;
    logic [31:0]   r_good,   n_good;
    logic [31:0]   r_drop,   n_drop;
    // written prefix of each bank: next unwritten pixel and lane
    logic [CW-1:0] r_fill_pix0, n_fill_pix0, r_fill_pix1, n_fill_pix1;
    logic [1:0]    r_fill_lane0, n_fill_lane0, r_fill_lane1, n_fill_lane1;

    logic          accept;
    logic [CMPW-1:0] cnt_x;
    logic [CW-1:0] eff;
    logic [XW-1:0] px_x, fp_x;
    logic [CW-1:0] back_fp, show_fp;
    logic [1:0]    back_fl, show_fl;
    logic          fill_hit;
    logic [CW-1:0] adv_fp;
    logic [1:0]    adv_fl;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        cnt_x = CMPW'(r_pix_count);
        if (cnt_x == '0) begin
            eff = CW'(1);
        end else if (cnt_x > CMPW'(MAX_PIXELS)) begin
            eff = CW'(MAX_PIXELS);
        end else begin
            eff = CW'(cnt_x);
        end
    end

    always_comb begin
        back_fp = r_bank ? r_fill_pix0  : r_fill_pix1;
        back_fl = r_bank ? r_fill_lane0 : r_fill_lane1;
        show_fp = r_bank ? r_fill_pix1  : r_fill_pix0;
        show_fl = r_bank ? r_fill_lane1 : r_fill_lane0;
        fill_hit = (back_fp == r_pix) && (back_fl == r_lane);
        adv_fp = (back_fl == LANE_BLUE) ? back_fp + CW'(1) : back_fp;
        adv_fl = (back_fl == LANE_BLUE) ? LANE_RED : back_fl + 2'd1;
        px_x = XW'(i_px);
        fp_x = XW'(show_fp);
    end

    always_comb begin
        n_state      = r_state;
        n_pix        = r_pix;
        n_lane       = r_lane;
        n_parity     = r_parity;
        n_age        = r_age;
        n_bank       = r_bank;
        n_good       = r_good;
        n_drop       = r_drop;
        n_fill_pix0  = r_fill_pix0;
        n_fill_pix1  = r_fill_pix1;
        n_fill_lane0 = r_fill_lane0;
        n_fill_lane1 = r_fill_lane1;
        o_cmd.wr_en   = 1'b0;
        o_cmd.lane    = r_lane;
        o_cmd.wdata   = i_byte;
        o_cmd.rd_mask = 3'b000;
        o_cmd.ev      = EV_NONE;
        o_addr        = {~r_bank, r_pix[PW-1:0]};

        case (i_op)
            OP_BYTE: begin
                case (r_state)
                    ST_SYNC2: begin
                        if (i_byte == SYNC_SECOND) begin
                            n_state  = ST_READ;
                            n_pix    = '0;
                            n_lane   = LANE_RED;
                            n_parity = '0;
                            n_age    = '0;
                        end else if (i_byte != SYNC_FIRST) begin
                            n_state = ST_SYNC1;
                        end
                    end
                    ST_READ: begin
                        if (r_pix < eff) begin
                            o_cmd.wr_en = 1'b1;
                            n_parity    = r_parity ^ i_byte;
                            n_lane      = (r_lane == LANE_BLUE) ? LANE_RED : r_lane + 2'd1;
                            n_pix       = (r_lane == LANE_BLUE) ? r_pix + CW'(1) : r_pix;
                            if (fill_hit) begin
                                if (r_bank) begin
                                    n_fill_pix0  = adv_fp;
                                    n_fill_lane0 = adv_fl;
                                end else begin
                                    n_fill_pix1  = adv_fp;
                                    n_fill_lane1 = adv_fl;
                                end
                            end
                        end else begin
                            if (r_parity == i_byte) begin
                                n_bank   = ~r_bank;
                                n_good   = r_good + 32'd1;
                                o_cmd.ev = EV_COMMIT;
                            end else begin
                                n_drop   = r_drop + 32'd1;
                                o_cmd.ev = EV_CSUM_FAIL;
                            end
                            n_state = ST_SYNC1;
                        end
                    end
                    default: begin
                        n_state = (i_byte == SYNC_FIRST) ? ST_SYNC2 : ST_SYNC1;
                    end
                endcase
            end
            OP_TICK: begin
                if (r_state == ST_READ) begin
                    if (r_age >= r_timeout) begin
                        n_state  = ST_SYNC1;
                        n_drop   = r_drop + 32'd1;
                        o_cmd.ev = EV_TIMEOUT;
                    end else begin
                        n_age = r_age + 16'd1;
                    end
                end
            end
            OP_READ: begin
                o_cmd.ev = EV_READ;
                o_addr   = {r_bank, PW'(px_x)};
                if (px_x < XW'(eff)) begin
                    o_cmd.rd_mask[LANE_RED] =
                        (px_x < fp_x) || ((px_x == fp_x) && (LANE_RED < show_fl));
                    o_cmd.rd_mask[LANE_GREEN] =
                        (px_x < fp_x) || ((px_x == fp_x) && (LANE_GREEN < show_fl));
                    o_cmd.rd_mask[LANE_BLUE] =
                        (px_x < fp_x) || ((px_x == fp_x) && (LANE_BLUE < show_fl));
                end
            end
            default: begin
            end
        endcase

        o_cmd.good    = n_good;
        o_cmd.dropped = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_count <= PIX_COUNT_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PIX_COUNT) begin
                r_pix_count <= i_cfg_data[8:0];
            end else begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SYNC1;
            r_pix        <= '0;
            r_lane       <= LANE_RED;
            r_parity     <= '0;
            r_age        <= '0;
            r_bank       <= 1'b0;
            r_good       <= '0;
            r_drop       <= '0;
            r_fill_pix0  <= '0;
            r_fill_pix1  <= '0;
            r_fill_lane0 <= LANE_RED;
            r_fill_lane1 <= LANE_RED;
        end else if (accept) begin
            r_state      <= n_state;
            r_pix        <= n_pix;
            r_lane       <= n_lane;
            r_parity     <= n_parity;
            r_age        <= n_age;
            r_bank       <= n_bank;
            r_good       <= n_good;
            r_drop       <= n_drop;
            r_fill_pix0  <= n_fill_pix0;
            r_fill_pix1  <= n_fill_pix1;
            r_fill_lane0 <= n_fill_lane0;
            r_fill_lane1 <= n_fill_lane1;
        end
    end

endmodule

/* rtl/lfxc_queue.sv */
// Small command queue between front end and pixel store.
`include "led_frame_receiver_xor_checksum_unit_assert.svh"
module lfxc_queue
    import lfxc_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = LFXC_QUEUE_DEPTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `LFXC_ASSERT(a_count_max, r_count <= CNTW'(DEPTH), "queue count above depth")
    `LFXC_ASSERT(a_no_push_full, i_push |-> !o_full, "push into full queue")
    `LFXC_ASSERT(a_no_pop_empty, i_pop |-> o_valid, "pop from empty queue")
    `LFXC_ASSERT(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + CNTW'(1)), "queue count did not advance on push")

endmodule

/* rtl/lfxc_back.sv */
// Back end: double-banked pixel store and registered result stage.
module lfxc_back
    import lfxc_pkg::*;
#(
    parameter int MAX_PIXELS = LFXC_MAX_PIXELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  t_cmd                            i_cmd,
    input  logic [lfxc_pix_w(MAX_PIXELS):0] i_addr,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_event_res,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [31:0]                     o_good_frames,
    output logic [31:0]                     o_dropped_frames
);

    localparam int AW = lfxc_pix_w(MAX_PIXELS) + 1;

    // one array per color; address is {bank, pixel}
    logic [7:0] r_mem_red   [2**AW];
    logic [7:0] r_mem_green [2**AW];
    logic [7:0] r_mem_blue  [2**AW];

    logic [7:0] r_rd_red, r_rd_green, r_rd_blue;
    t_cmd       r_cmd;
    logic       r_valid, n_valid;

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr_en) begin
            if (i_cmd.lane == LANE_RED) begin
                r_mem_red[i_addr] <= i_cmd.wdata;
            end
            if (i_cmd.lane == LANE_GREEN) begin
                r_mem_green[i_addr] <= i_cmd.wdata;
            end
            if (i_cmd.lane == LANE_BLUE) begin
                r_mem_blue[i_addr] <= i_cmd.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_red   <= r_mem_red[i_addr];
            r_rd_green <= r_mem_green[i_addr];
            r_rd_blue  <= r_mem_blue[i_addr];
            r_cmd      <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // bytes never written since reset read as black
    assign o_valid          = r_valid;
    assign o_event_res      = r_cmd.ev;
    assign o_red            = r_cmd.rd_mask[LANE_RED]   ? r_rd_red   : 8'd0;
    assign o_green          = r_cmd.rd_mask[LANE_GREEN] ? r_rd_green : 8'd0;
    assign o_blue           = r_cmd.rd_mask[LANE_BLUE]  ? r_rd_blue  : 8'd0;
    assign o_good_frames    = r_cmd.good;
    assign o_dropped_frames = r_cmd.dropped;

endmodule

/* rtl/led_frame_receiver_xor_checksum_unit.sv */
// Top level: sync-word framed pixel receiver with XOR checksum.
// Result path: an accepted input is registered into a queue entry, then into the store read stage.
// Throughput: one item per cycle while the queue has room and the output is ready;
// the store takes one write or one pixel read per cycle.
// Reset: synchronous, active low; per-bank fill marks make unwritten pixels read as
// zero, so no clearing pass is needed and items are taken right after reset.
module led_frame_receiver_xor_checksum_unit
    import lfxc_pkg::*;
#(
    parameter int MAX_PIXELS = LFXC_MAX_PIXELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [15:8] pixel_index
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // red, green, blue, good_frames, dropped_frames, pad
    output logic [2:0]  o_m_tuser    // [2:0] event_res
);

    localparam int AW = lfxc_pix_w(MAX_PIXELS) + 1;
    localparam int QW = $bits(t_cmd) + AW;

    t_cmd          front_cmd, back_cmd;
    logic [AW-1:0] front_addr, back_addr;
    logic          push, q_full, q_valid, pop;
    logic [QW-1:0] q_out;
    logic [7:0]    red, green, blue;
    logic [31:0]   good_frames, dropped_frames;

    lfxc_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_op       (i_s_tuser),
        .i_byte     (i_s_tdata[7:0]),
        .i_px       (i_s_tdata[15:8]),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .o_addr     (front_addr)
    );

    lfxc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cmd, front_addr}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign back_cmd  = q_out[QW-1:AW];
    assign back_addr = q_out[AW-1:0];

    lfxc_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_pop            (pop),
        .i_cmd            (back_cmd),
        .i_addr           (back_addr),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_event_res      (o_m_tuser),
        .o_red            (red),
        .o_green          (green),
        .o_blue           (blue),
        .o_good_frames    (good_frames),
        .o_dropped_frames (dropped_frames)
    );

    assign o_m_tdata = {8'd0, dropped_frames, good_frames, blue, green, red};

endmodule
